>>> design/hhlt_pkg.sv
package hhlt_pkg;

    // default depth of the name store
    localparam int NAME_MAX_DEF = 48;

    // name length counter width, enough for the largest store of 63 bytes
    localparam int LEN_W = 6;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // token kinds on the result side
    localparam logic [1:0] TK_NAME  = 2'd0;
    localparam logic [1:0] TK_VALUE = 2'd1;
    localparam logic [1:0] TK_END   = 2'd2;

    // length of the status line prefix
    localparam logic [2:0] STATUS_LEN = 3'd5;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_DROP
    } phase_t;

    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_VALUE,
        MAIN_DUMP
    } main_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CR,
        BK_VAL,
        BK_RD,
        BK_WAIT,
        BK_END
    } back_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] out_byte;
        logic       name_truncated;
        logic       run_last;
    } result_t;

    // per-line parser state
    typedef struct packed {
        phase_t           phase;
        logic [LEN_W-1:0] len;
        logic [2:0]       pos;
        logic             seen;
        logic             ovf;
    } line_t;

    localparam line_t LINE_RESET = '{
        phase: PH_NAME,
        len:   '0,
        pos:   '0,
        seen:  1'b1,
        ovf:   1'b0
    };

    // work for the back end caused by one input transaction
    typedef struct packed {
        logic             cr_val;
        main_t            main;
        logic [7:0]       main_byte;
        logic [LEN_W-1:0] dump_len;
        logic             end_mark;
        logic             trunc;
    } cmd_t;

    // characters of the status line prefix "HTTP/"
    function automatic logic [7:0] status_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> design/hhlt_ram.sv
module hhlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read that holds when not enabled
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/hhlt_front.sv
module hhlt_front
    import hhlt_pkg::*;
#(
    parameter int NAME_MAX = NAME_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  item_t                       item,
    output logic                        full,
    output logic                        cmd_push,
    output cmd_t                        cmd,
    input  logic                        cmdq_full,
    input  logic                        dump_done,
    output logic                        ram_wr_en,
    output logic [$clog2(NAME_MAX)-1:0] ram_wr_addr,
    output logic [7:0]                  ram_wr_data
);

    localparam int AW = $clog2(NAME_MAX);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(NAME_MAX);

    typedef struct packed {
        line_t s;
        logic  emit_val;
        logic  dump;
        logic  wr;
    } step_t;

    line_t            line_reg, line_next;
    logic             cr_reg, cr_next;
    logic             dump_pending_reg, dump_pending_next;
    logic             accept;
    logic             wr_en;
    logic             ended;
    logic [LEN_W-1:0] len_mid;
    step_t            r1, r2;
    cmd_t             cmd_c;

    // one content byte applied to the line state
    function automatic step_t do_content(input line_t s, input logic [7:0] x);
        step_t r;
        r.s        = s;
        r.emit_val = 1'b0;
        r.dump     = 1'b0;
        r.wr       = 1'b0;
        case (s.phase)
            PH_NAME:
            begin
                if (x == CH_COLON)
                begin
                    r.dump    = 1'b1;
                    r.s.phase = PH_SKIP;
                end
                else
                begin
                    if (s.pos < STATUS_LEN)
                    begin
                        if (x != status_char(s.pos))
                        begin
                            r.s.seen = 1'b0;
                        end
                        r.s.pos = s.pos + 3'd1;
                    end
                    if (s.len < LEN_LIMIT)
                    begin
                        r.wr    = 1'b1;
                        r.s.len = s.len + LEN_W'(1);
                    end
                    else
                    begin
                        r.s.ovf = 1'b1;
                    end
                    if (r.s.pos == STATUS_LEN && r.s.seen)
                    begin
                        r.s.phase = PH_DROP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (x != CH_SPACE && x != CH_TAB)
                begin
                    r.s.phase  = PH_VALUE;
                    r.emit_val = 1'b1;
                end
            end
            PH_VALUE:
            begin
                r.emit_val = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // input side stalls on a full command queue or a name dump in flight
    assign full   = cmdq_full || dump_pending_reg;
    assign accept = push && !full;

    // classify the byte: held cr first, then the byte, then end of buffer
    always_comb
    begin
        line_next = line_reg;
        cr_next   = cr_reg;
        cmd_c     = '0;
        ended     = 1'b0;
        wr_en     = 1'b0;
        r1        = '0;
        r2        = '0;
        if (cr_reg)
        begin
            cr_next = 1'b0;
            if (item.in_byte == CH_LF)
            begin
                cmd_c.end_mark = (line_next.phase == PH_SKIP) ||
                                 (line_next.phase == PH_VALUE);
                cmd_c.trunc    = line_next.ovf;
                line_next      = LINE_RESET;
                ended          = 1'b1;
            end
            else
            begin
                // the cr byte was already written to the store on arrival
                r1           = do_content(line_next, CH_CR);
                line_next    = r1.s;
                cmd_c.cr_val = r1.emit_val;
                cmd_c.trunc  = line_next.ovf;
            end
        end
        len_mid = line_next.len;
        if (!ended)
        begin
            if (item.in_byte == CH_CR && !item.end_of_buffer)
            begin
                // hold cr, store it ahead in case it turns out to be content
                cr_next = 1'b1;
                wr_en   = (line_next.phase == PH_NAME) && (line_next.len < LEN_LIMIT);
            end
            else
            begin
                r2              = do_content(line_next, item.in_byte);
                line_next       = r2.s;
                wr_en           = r2.wr;
                cmd_c.main_byte = item.in_byte;
                cmd_c.dump_len  = len_mid;
                cmd_c.trunc     = line_next.ovf;
                if (r2.emit_val)
                begin
                    cmd_c.main = MAIN_VALUE;
                end
                else if (r2.dump && len_mid != '0)
                begin
                    cmd_c.main = MAIN_DUMP;
                end
                if (item.end_of_buffer)
                begin
                    cmd_c.end_mark = (line_next.phase == PH_SKIP) ||
                                     (line_next.phase == PH_VALUE);
                    line_next      = LINE_RESET;
                end
            end
        end
    end

    assign cmd         = cmd_c;
    assign cmd_push    = accept && (cmd_c.cr_val || cmd_c.main != MAIN_NONE || cmd_c.end_mark);
    assign ram_wr_en   = accept && wr_en;
    assign ram_wr_addr = len_mid[AW-1:0];
    assign ram_wr_data = item.in_byte;

    // dump outstanding flag
    always_comb
    begin
        dump_pending_next = dump_pending_reg;
        if (dump_done)
        begin
            dump_pending_next = 1'b0;
        end
        else if (cmd_push && cmd_c.main == MAIN_DUMP)
        begin
            dump_pending_next = 1'b1;
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg         <= LINE_RESET;
            cr_reg           <= 1'b0;
            dump_pending_reg <= 1'b0;
        end
        else
        begin
            dump_pending_reg <= dump_pending_next;
            if (accept)
            begin
                line_reg <= line_next;
                cr_reg   <= cr_next;
            end
        end
    end

endmodule

>>> design/hhlt_cmdq.sv
module hhlt_cmdq
    import hhlt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    output logic valid,
    input  logic pop,
    output cmd_t dout
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> design/hhlt_back.sv
module hhlt_back
    import hhlt_pkg::*;
#(
    parameter int NAME_MAX = NAME_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  cmd_t                        cmd,
    output logic                        cmd_pop,
    output logic                        ram_rd_en,
    output logic [$clog2(NAME_MAX)-1:0] ram_rd_addr,
    input  logic [7:0]                  ram_rd_data,
    output logic                        dump_done,
    output result_t                     result,
    output logic                        empty,
    input  logic                        pop
);

    localparam int AW = $clog2(NAME_MAX);

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    result_t          out_reg, emit_res;
    logic             out_valid_reg;
    logic             out_free;
    logic             emit;
    logic             idx_last;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    assign out_free    = !out_valid_reg || pop;
    assign idx_last    = (idx_reg + LEN_W'(1)) == cmd_reg.dump_len;
    assign ram_rd_addr = idx_reg[AW-1:0];
    assign result      = out_reg;
    assign empty       = !out_valid_reg;

    // sequencer expanding one command into its results
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        ram_rd_en  = 1'b0;
        dump_done  = 1'b0;
        emit       = 1'b0;
        emit_res   = '0;
        emit_res.name_truncated = cmd_reg.trunc;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    idx_next = '0;
                    if (cmd.cr_val)
                    begin
                        state_next = BK_CR;
                    end
                    else if (cmd.main == MAIN_VALUE)
                    begin
                        state_next = BK_VAL;
                    end
                    else if (cmd.main == MAIN_DUMP)
                    begin
                        state_next = BK_RD;
                    end
                    else
                    begin
                        state_next = BK_END;
                    end
                end
            end
            BK_CR:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_res.token_kind = TK_VALUE;
                    emit_res.out_byte   = CH_CR;
                    emit_res.run_last   = (cmd_reg.main == MAIN_NONE) && !cmd_reg.end_mark;
                    if (cmd_reg.main == MAIN_VALUE)
                    begin
                        state_next = BK_VAL;
                    end
                    else if (cmd_reg.end_mark)
                    begin
                        state_next = BK_END;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_VAL:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_res.token_kind = TK_VALUE;
                    emit_res.out_byte   = cmd_reg.main_byte;
                    emit_res.run_last   = !cmd_reg.end_mark;
                    if (cmd_reg.end_mark)
                    begin
                        state_next = BK_END;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_res.token_kind = TK_NAME;
                    emit_res.out_byte   = to_lower(ram_rd_data);
                    emit_res.run_last   = idx_last && !cmd_reg.end_mark;
                    idx_next            = idx_reg + LEN_W'(1);
                    if (idx_last)
                    begin
                        dump_done = 1'b1;
                        if (cmd_reg.end_mark)
                        begin
                            state_next = BK_END;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = BK_RD;
                    end
                end
            end
            BK_END:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_res.token_kind = TK_END;
                    emit_res.out_byte   = 8'h00;
                    emit_res.run_last   = 1'b1;
                    state_next          = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // command and index registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_res;
        end
    end

endmodule

>>> design/http_header_line_tokenizer_top.sv
// HTTP header line tokenizer. Takes one raw byte of a response header block per
// transaction (end_of_buffer on the final byte) and gives name bytes (lowercased),
// value bytes (leading blanks skipped) and an end marker for each header line;
// status lines, empty lines and lines without a colon give nothing. The front end
// takes a byte per cycle while the two-entry command queue has room and no name
// replay is outstanding; the back end takes each byte's command from the queue and
// then gives its value or end results in turn. A name is replayed from the name
// store one byte at a time (registered read of the single read port), and input is
// held off from the colon until the last name byte has entered the output register.
// The name store is not cleared after reset and needs no start-up pass.
module http_header_line_tokenizer_top
    import hhlt_pkg::*;
#(
    parameter int NAME_MAX = NAME_MAX_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   item,
    output logic    full,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int AW = $clog2(NAME_MAX);

    logic          cmdq_push, cmdq_full, cmdq_valid, cmdq_pop;
    cmd_t          cmdq_din, cmdq_dout;
    logic          dump_done;
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [7:0]    ram_wr_data, ram_rd_data;

    // classifier and line state
    hhlt_front #(
        .NAME_MAX (NAME_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (full),
        .cmd_push    (cmdq_push),
        .cmd         (cmdq_din),
        .cmdq_full   (cmdq_full),
        .dump_done   (dump_done),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    // command queue between front and back
    hhlt_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmdq_push),
        .din   (cmdq_din),
        .full  (cmdq_full),
        .valid (cmdq_valid),
        .pop   (cmdq_pop),
        .dout  (cmdq_dout)
    );

    // name store
    hhlt_ram #(
        .WIDTH (8),
        .DEPTH (NAME_MAX)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result sequencer
    hhlt_back #(
        .NAME_MAX (NAME_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmdq_valid),
        .cmd         (cmdq_dout),
        .cmd_pop     (cmdq_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .dump_done   (dump_done),
        .result      (result),
        .empty       (empty),
        .pop         (pop)
    );

    // name store is never written while a name is being replayed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("name store write during replay");

    // the command queue is never pushed when full
    assert property (@(posedge clk) disable iff (!rst_n)
        cmdq_push |-> !cmdq_full)
        else $error("command queue overflow");

    // an end marker carries a zero byte and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.token_kind == TK_END) |-> (result.out_byte == 8'h00 && result.run_last))
        else $error("malformed end marker");

endmodule
